// ===== hw/rtl/rbf_pkg.sv =====
// ---------------------------------------------------------------------------
// rbf_pkg
// Shared types and codes for the rewindable byte fifo: transaction payloads,
// function codes and the sequencer states.
// ---------------------------------------------------------------------------
package rbf_pkg;

	localparam int unsigned FuncW  = 3;
	localparam int unsigned WordW  = 32;
	localparam int unsigned NbW    = 3;
	localparam int unsigned CountW = 11;

	// bytes that fit in one data word
	localparam logic [NbW-1:0] WordBytes = NbW'(WordW / 8);

	localparam logic [FuncW-1:0] FUNC_WRITE  = 3'd0;
	localparam logic [FuncW-1:0] FUNC_READ   = 3'd1;
	localparam logic [FuncW-1:0] FUNC_REWIND = 3'd2;
	localparam logic [FuncW-1:0] FUNC_COMMIT = 3'd3;
	localparam logic [FuncW-1:0] FUNC_CLEAR  = 3'd4;

	typedef struct packed {
		logic [FuncW-1:0] func;
		logic [WordW-1:0] wdata;
		logic [NbW-1:0]   nbytes;
	} in_item_t;

	typedef struct packed {
		logic [WordW-1:0]  rdata;
		logic              rvalid;
		logic              write_dropped;
		logic [CountW-1:0] avail_count;
		logic [CountW-1:0] read_uncommitted;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_RD_LAST,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/rbf_ram.sv =====
// ---------------------------------------------------------------------------
// rbf_ram
// Byte-wide single-write, single-read synchronous memory with registered
// read data.
// ---------------------------------------------------------------------------
module rbf_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/rewindable_byte_fifo_unit.sv =====
// ---------------------------------------------------------------------------
// rewindable_byte_fifo_unit
// Byte fifo in a ring memory with a speculative read pointer: reads can be
// rewound to the oldest kept byte or committed to free the bytes.
// ---------------------------------------------------------------------------
//
//  channel | signals                      | payload
//  --------+------------------------------+------------------------------
//  in      | in_valid / in_ready          | in_data  (func, wdata, nbytes)
//  out     | out_valid / out_ready        | out_data (rdata, rvalid, ...)
//
// a write that stores n >= 1 bytes passes ST_WR once per byte, a read that
// returns n >= 1 bytes ST_RD once per byte then ST_RD_LAST; every other
// transaction (dropped write, short read, zero length, rewind, commit, clear,
// spare code) goes straight to ST_DONE; the byte-wide memory sets this, one byte per cycle
// one transaction is in work at a time; the next is taken while the last
// result still waits in the output register
// reset clears control registers only; the ring memory needs no clearing
// a stalled output holds the sequencer in its final state until taken
//
module rewindable_byte_fifo_unit #(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned MAX_BYTES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rbf_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rbf_pkg::out_item_t out_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
	localparam logic [CW:0]   DepthSum = (CW + 1)'(DEPTH);
	localparam logic [rbf_pkg::NbW:0] MaxBytes = (rbf_pkg::NbW + 1)'(MAX_BYTES);

	rbf_pkg::state_t state_q, state_d;

	logic [rbf_pkg::FuncW-1:0] func_q;
	logic [rbf_pkg::WordW-1:0] wdata_q;
	logic [rbf_pkg::NbW-1:0]   n_q;
	logic [rbf_pkg::NbW-1:0]   idx_q;

	logic [AW-1:0] oldest_q, rptr_q, wptr_q;
	logic [CW-1:0] unread_q, rdcnt_q;

	logic [rbf_pkg::WordW-1:0] rdata_q;
	logic                      rvalid_q;
	logic                      dropped_q;

	logic                    pend_s1;
	logic [rbf_pkg::NbW-1:0] pidx_s1;

	logic               out_valid_q;
	rbf_pkg::out_item_t out_data_q;

	logic                    acc;
	logic [rbf_pkg::NbW-1:0] n_in;
	logic [CW:0]             kept_sum;
	logic                    fits;
	logic                    have;
	logic                    last_step;
	logic                    out_free;
	logic                    out_load;
	logic                    mem_we;
	logic                    mem_re;
	logic [7:0]              mem_wbyte;
	logic [7:0]              mem_rbyte;
	logic [AW-1:0]           wptr_next, rptr_next;
	logic [CW+rbf_pkg::CountW-1:0] avail_wide, uncommitted_wide;

	// decode of the incoming transaction
	assign acc  = in_valid && in_ready;
	assign n_in = ({1'b0, in_data.nbytes} > MaxBytes) ? MaxBytes[rbf_pkg::NbW-1:0]
		: in_data.nbytes;
	assign kept_sum = {1'b0, rdcnt_q} + {1'b0, unread_q} + (CW + 1)'(n_in);
	assign fits     = kept_sum <= DepthSum;
	assign have     = unread_q >= CW'(n_in);

	assign last_step = idx_q == (n_q - 3'd1);
	assign out_free  = !out_valid_q || out_ready;
	assign wptr_next = (wptr_q == LastAddr) ? '0 : wptr_q + 1'b1;
	assign rptr_next = (rptr_q == LastAddr) ? '0 : rptr_q + 1'b1;

	// bytes past the data word are stored as zero
	assign mem_wbyte = (idx_q < rbf_pkg::WordBytes) ? wdata_q[{idx_q[1:0], 3'b000} +: 8]
		: 8'h00;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbf_pkg::ST_IDLE: begin
				if (acc) begin
					case (in_data.func)
						rbf_pkg::FUNC_WRITE: begin
							state_d = (fits && n_in != '0) ? rbf_pkg::ST_WR : rbf_pkg::ST_DONE;
						end
						rbf_pkg::FUNC_READ: begin
							state_d = (have && n_in != '0) ? rbf_pkg::ST_RD : rbf_pkg::ST_DONE;
						end
						default: begin
							state_d = rbf_pkg::ST_DONE;
						end
					endcase
				end
			end
			rbf_pkg::ST_WR: begin
				if (last_step) begin
					state_d = rbf_pkg::ST_DONE;
				end
			end
			rbf_pkg::ST_RD: begin
				if (last_step) begin
					state_d = rbf_pkg::ST_RD_LAST;
				end
			end
			rbf_pkg::ST_RD_LAST: begin
				state_d = rbf_pkg::ST_DONE;
			end
			rbf_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rbf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rbf_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			rbf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			rbf_pkg::ST_WR: begin
				mem_we = 1'b1;
			end
			rbf_pkg::ST_RD: begin
				mem_re = 1'b1;
			end
			rbf_pkg::ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbf_pkg::ST_IDLE;
			oldest_q    <= '0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			unread_q    <= '0;
			rdcnt_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= mem_re;
			if (acc) begin
				idx_q <= '0;
				case (in_data.func)
					rbf_pkg::FUNC_REWIND: begin
						rptr_q   <= oldest_q;
						unread_q <= unread_q + rdcnt_q;
						rdcnt_q  <= '0;
					end
					rbf_pkg::FUNC_COMMIT: begin
						oldest_q <= rptr_q;
						rdcnt_q  <= '0;
					end
					rbf_pkg::FUNC_CLEAR: begin
						oldest_q <= '0;
						rptr_q   <= '0;
						wptr_q   <= '0;
						unread_q <= '0;
						rdcnt_q  <= '0;
					end
					default: begin
						rdcnt_q <= rdcnt_q;
					end
				endcase
			end else if (mem_we) begin
				idx_q  <= idx_q + 1'b1;
				wptr_q <= wptr_next;
				if (last_step) begin
					unread_q <= unread_q + CW'(n_q);
				end
			end else if (mem_re) begin
				idx_q  <= idx_q + 1'b1;
				rptr_q <= rptr_next;
				if (last_step) begin
					unread_q <= unread_q - CW'(n_q);
					rdcnt_q  <= rdcnt_q + CW'(n_q);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		pidx_s1 <= idx_q;
		if (acc) begin
			func_q    <= in_data.func;
			wdata_q   <= in_data.wdata;
			n_q       <= n_in;
			rdata_q   <= '0;
			rvalid_q  <= (in_data.func == rbf_pkg::FUNC_READ) && have;
			dropped_q <= (in_data.func == rbf_pkg::FUNC_WRITE) && !fits;
		end else if (pend_s1 && pidx_s1 < rbf_pkg::WordBytes) begin
			// read byte lands in the cycle after its address was issued
			rdata_q[{pidx_s1[1:0], 3'b000} +: 8] <= mem_rbyte;
		end
		if (out_load) begin
			out_data_q.rdata            <= rdata_q;
			out_data_q.rvalid           <= rvalid_q;
			out_data_q.write_dropped    <= dropped_q;
			out_data_q.avail_count      <= avail_wide[rbf_pkg::CountW-1:0];
			out_data_q.read_uncommitted <= uncommitted_wide[rbf_pkg::CountW-1:0];
		end
	end

	assign avail_wide       = {{rbf_pkg::CountW{1'b0}}, unread_q};
	assign uncommitted_wide = {{rbf_pkg::CountW{1'b0}}, rdcnt_q};

	rbf_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wptr_q),
		.wdata (mem_wbyte),
		.re    (mem_re),
		.raddr (rptr_q),
		.rdata (mem_rbyte)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// kept bytes never exceed the ring
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, unread_q} + {1'b0, rdcnt_q}) <= DepthSum)
		else $error("kept byte count exceeds ring depth");

	// one transaction at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !in_ready)
		else $error("transaction taken while another is in work");

	// a result is either a satisfied read or a dropped write, never both
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.rvalid && out_data_q.write_dropped))
		else $error("read and drop flags both set");

	// a read under way only for a read transaction
	a_read_func: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re || mem_we) |-> (func_q == rbf_pkg::FUNC_READ) == mem_re)
		else $error("memory access does not match function");

endmodule
